FILE: hdl/irpwd_pkg.sv
// Shared types and constants for the infrared pulse-width decoder.
`timescale 1ns / 1ps
`default_nettype none

package irpwd_pkg;

    localparam int unsigned COUNT_W     = 16;
    localparam int unsigned CODE_W      = 32;
    localparam int unsigned REPEAT_W    = 8;
    localparam int unsigned CFG_INDEX_W = 4;

    localparam logic [COUNT_W-1:0] NOISE_FLOOR = 16'd10;

    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MIN  = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SHORT_MAX  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_MIN   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_MAX   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_MIN = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_MAX = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MIN = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_LEADER_MAX = 4'd7;

    localparam logic [COUNT_W-1:0] RST_SHORT_MIN  = 16'd900;
    localparam logic [COUNT_W-1:0] RST_SHORT_MAX  = 16'd2400;
    localparam logic [COUNT_W-1:0] RST_LONG_MIN   = 16'd4200;
    localparam logic [COUNT_W-1:0] RST_LONG_MAX   = 16'd5400;
    localparam logic [COUNT_W-1:0] RST_REPEAT_MIN = 16'd6600;
    localparam logic [COUNT_W-1:0] RST_REPEAT_MAX = 16'd7800;
    localparam logic [COUNT_W-1:0] RST_LEADER_MIN = 16'd12600;
    localparam logic [COUNT_W-1:0] RST_LEADER_MAX = 16'd14100;

    typedef enum logic [2:0] {
        CLASS_NONE   = 3'd0,
        CLASS_ONE    = 3'd1,
        CLASS_ZERO   = 3'd2,
        CLASS_REPEAT = 3'd3,
        CLASS_LEADER = 3'd4
    } pulse_class_t;

    typedef struct packed {
        logic [COUNT_W-1:0] short_min;
        logic [COUNT_W-1:0] short_max;
        logic [COUNT_W-1:0] long_min;
        logic [COUNT_W-1:0] long_max;
        logic [COUNT_W-1:0] repeat_min;
        logic [COUNT_W-1:0] repeat_max;
        logic [COUNT_W-1:0] leader_min;
        logic [COUNT_W-1:0] leader_max;
    } windows_t;

    typedef struct packed {
        logic [CODE_W-1:0]   code_word;
        logic                code_done;
        logic [REPEAT_W-1:0] repeat_total;
        logic                frame_active;
        pulse_class_t        pulse_class;
    } result_t;

endpackage

`default_nettype wire

FILE: hdl/irpwd_cfg_regs.sv
// Window bound registers written through the configuration port.
`timescale 1ns / 1ps
`default_nettype none

module irpwd_cfg_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [irpwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [irpwd_pkg::COUNT_W-1:0]     cfg_data,
    output irpwd_pkg::windows_t                   windows
);
    import irpwd_pkg::*;

    windows_t win_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg.short_min  <= RST_SHORT_MIN;
            win_reg.short_max  <= RST_SHORT_MAX;
            win_reg.long_min   <= RST_LONG_MIN;
            win_reg.long_max   <= RST_LONG_MAX;
            win_reg.repeat_min <= RST_REPEAT_MIN;
            win_reg.repeat_max <= RST_REPEAT_MAX;
            win_reg.leader_min <= RST_LEADER_MIN;
            win_reg.leader_max <= RST_LEADER_MAX;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SHORT_MIN:  win_reg.short_min  <= cfg_data;
                REG_SHORT_MAX:  win_reg.short_max  <= cfg_data;
                REG_LONG_MIN:   win_reg.long_min   <= cfg_data;
                REG_LONG_MAX:   win_reg.long_max   <= cfg_data;
                REG_REPEAT_MIN: win_reg.repeat_min <= cfg_data;
                REG_REPEAT_MAX: win_reg.repeat_max <= cfg_data;
                REG_LEADER_MIN: win_reg.leader_min <= cfg_data;
                REG_LEADER_MAX: win_reg.leader_max <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign windows = win_reg;

endmodule

`default_nettype wire

FILE: hdl/irpwd_classify.sv
// Sorts one captured interval into a pulse window.
`timescale 1ns / 1ps
`default_nettype none

module irpwd_classify (
    input  wire logic                         edge_level,
    input  wire logic [irpwd_pkg::COUNT_W-1:0] interval_count,
    input  wire logic                         in_frame,
    input  wire irpwd_pkg::windows_t          windows,
    output irpwd_pkg::pulse_class_t           pulse_class
);
    import irpwd_pkg::*;

    logic [COUNT_W-1:0] iv;
    logic               hit_short;
    logic               hit_long;
    logic               hit_repeat;
    logic               hit_leader;

    // Intervals at or below the noise floor count as zero length.
    assign iv = (interval_count <= NOISE_FLOOR) ? '0 : interval_count;

    assign hit_short  = (iv > windows.short_min)  && (iv < windows.short_max);
    assign hit_long   = (iv > windows.long_min)   && (iv < windows.long_max);
    assign hit_repeat = (iv > windows.repeat_min) && (iv < windows.repeat_max);
    assign hit_leader = (iv > windows.leader_min) && (iv < windows.leader_max);

    always_comb
    begin
        pulse_class = CLASS_NONE;
        priority if (edge_level)
            pulse_class = CLASS_NONE;
        else if (!in_frame)
            pulse_class = hit_leader ? CLASS_LEADER : CLASS_NONE;
        else if (hit_short)
            pulse_class = CLASS_ONE;
        else if (hit_long)
            pulse_class = CLASS_ZERO;
        else if (hit_repeat)
            pulse_class = CLASS_REPEAT;
        else
            pulse_class = CLASS_NONE;
    end

endmodule

`default_nettype wire

FILE: hdl/irpwd_frame_state.sv
// Frame state: shift word, bit count, latched code and repeat count.
`timescale 1ns / 1ps
`default_nettype none

module irpwd_frame_state #(
    parameter int unsigned CODE_BITS = 32
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    step,
    input  wire irpwd_pkg::pulse_class_t pulse_class,
    output logic                         in_frame,
    output irpwd_pkg::result_t           result
);
    import irpwd_pkg::*;

    localparam int unsigned BITS_W = $clog2(CODE_BITS + 1);

    logic                in_frame_reg;
    logic                in_frame_next;
    logic [CODE_W-1:0]   shift_reg;
    logic [CODE_W-1:0]   shift_next;
    logic [BITS_W-1:0]   bits_reg;
    logic [BITS_W-1:0]   bits_next;
    logic [CODE_W-1:0]   code_reg;
    logic [CODE_W-1:0]   code_next;
    logic [REPEAT_W-1:0] repeat_reg;
    logic [REPEAT_W-1:0] repeat_next;
    logic                done;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        shift_next    = shift_reg;
        bits_next     = bits_reg;
        code_next     = code_reg;
        repeat_next   = repeat_reg;
        done          = 1'b0;
        unique case (pulse_class)
            CLASS_ONE:
            begin
                shift_next = {shift_reg[CODE_W-2:0], 1'b1};
                bits_next  = bits_reg + 1'b1;
            end
            CLASS_ZERO:
            begin
                shift_next = {shift_reg[CODE_W-2:0], 1'b0};
                bits_next  = bits_reg + 1'b1;
            end
            CLASS_REPEAT:
                repeat_next = repeat_reg + 1'b1;
            CLASS_LEADER:
            begin
                in_frame_next = 1'b1;
                repeat_next   = '0;
                code_next     = '0;
                bits_next     = '0;
            end
            default: ;
        endcase
        if ((pulse_class == CLASS_ONE || pulse_class == CLASS_ZERO) &&
            bits_next == BITS_W'(CODE_BITS))
        begin
            code_next  = shift_next;
            shift_next = '0;
            bits_next  = '0;
            done       = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            shift_reg    <= '0;
            bits_reg     <= '0;
            code_reg     <= '0;
            repeat_reg   <= '0;
        end
        else if (step)
        begin
            in_frame_reg <= in_frame_next;
            shift_reg    <= shift_next;
            bits_reg     <= bits_next;
            code_reg     <= code_next;
            repeat_reg   <= repeat_next;
        end
    end

    assign in_frame            = in_frame_reg;
    assign result.code_word    = code_next;
    assign result.code_done    = done;
    assign result.repeat_total = repeat_next;
    assign result.frame_active = in_frame_next;
    assign result.pulse_class  = pulse_class;

endmodule

`default_nettype wire

FILE: hdl/ir_pulse_width_decoder_unit.sv
// Top level of the infrared pulse-width decoder with its stream ports.
//
// Capture events enter on the s_axis group: s_axis_tuser is the line level
// (one for a rising edge, which is reported but not decoded) and s_axis_tdata
// is the captured interval count. Every request produces exactly one result
// request on the m_axis group, in order.
// The result carries the latched code, the repeat count and the frame flag in
// m_axis_tdata, the pulse class in m_axis_tuser, and m_axis_tlast marks the
// event that completed a code word.
// An event is registered at the input, then classified and applied to the frame
// state while its result is captured in an output register. One event can be
// accepted every cycle while the receiver does not stall, set by the single
// input and output register pair.
// When the receiver stalls, the held result stays in place and one more event
// may wait in the input register; after that s_axis_tready falls.
// Reset clears the frame state, empties both registers and restores the
// default window bounds. Bounds are written through cfg_we, cfg_index and
// cfg_data by the user, only while no event is in flight; the block does not enforce it.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_width_decoder_unit #(
    parameter int unsigned CODE_BITS = 32
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [15:0]                      s_axis_tdata,  // [15:0] interval_count
    input  wire logic                             s_axis_tuser,  // [0] edge_level
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    // [31:0] code_word, [39:32] repeat_total, [40] frame_active, [47:41] zero
    output logic [47:0]                           m_axis_tdata,
    output logic                                  m_axis_tlast,  // code_done
    output logic [2:0]                            m_axis_tuser,  // [2:0] pulse_class
    input  wire logic                             cfg_we,
    input  wire logic [irpwd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [irpwd_pkg::COUNT_W-1:0]     cfg_data
);
    import irpwd_pkg::*;

    windows_t           windows;
    logic               in_valid_reg;
    logic               level_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               out_valid_reg;
    result_t            out_reg;
    logic               advance;
    logic               step;
    logic               in_frame;
    pulse_class_t       pulse_class;
    result_t            result;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;

    irpwd_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .windows   (windows)
    );

    irpwd_classify u_classify (
        .edge_level     (level_reg),
        .interval_count (count_reg),
        .in_frame       (in_frame),
        .windows        (windows),
        .pulse_class    (pulse_class)
    );

    irpwd_frame_state #(
        .CODE_BITS (CODE_BITS)
    ) u_state (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .pulse_class (pulse_class),
        .in_frame    (in_frame),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            level_reg <= s_axis_tuser;
            count_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_reg.frame_active, out_reg.repeat_total,
                            out_reg.code_word};
    assign m_axis_tlast  = out_reg.code_done;
    assign m_axis_tuser  = out_reg.pulse_class;

endmodule

`default_nettype wire

FILE: hdl/irpwd_checker.sv
// Port-level checks for the pulse-width decoder and their binding.
`timescale 1ns / 1ps
`default_nettype none

module irpwd_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [47:0] m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic [2:0]  m_axis_tuser
);
    import irpwd_pkg::*;

    // A completed code can only come from a bit pulse inside a frame.
    a_done_on_bit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |->
        ((m_axis_tuser == CLASS_ONE || m_axis_tuser == CLASS_ZERO) &&
         m_axis_tdata[40]))
    else $error("code completion without a bit pulse in a frame");

    // A leader clears the code and repeat count and opens the frame.
    a_leader_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == CLASS_LEADER) |->
        (m_axis_tdata[39:0] == 40'd0 && m_axis_tdata[40] && !m_axis_tlast))
    else $error("leader result does not show a cleared frame");

    // Any non-empty class other than leader needs an open frame.
    a_class_needs_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != CLASS_NONE) |-> m_axis_tdata[40])
    else $error("decoded pulse reported outside a frame");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
         $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind ir_pulse_width_decoder_unit irpwd_checker u_irpwd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
